// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 11;
  // wide enough for (ROWS-1)*COLS+COLS-1 at the largest geometry
  localparam int IDXC_W  = 12;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] TAB_STEP = 8'd8;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_SPACE};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]        cursor_col;
    logic [4:0]        cursor_row;
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_data;
  } tcw_out_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Text memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = COLS_DEF * ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcw_seq.sv =====
// Command sequencer: cursor, fill/scroll walks over the text memory, result register.
`timescale 1ns / 1ps

module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  localparam int CELLS = COLS * ROWS,
  localparam int AW = $clog2(CELLS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tcw_in_t            in_data,
  output logic               busy,
  input  logic [COLOR_W-1:0] color,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [CELL_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [CELL_W-1:0]  mem_rdata,
  output logic               out_valid,
  output tcw_out_t           out_data
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_CLEAR  = 8'b0001_0000,
    S_SCROLL = 8'b0010_0000,
    S_BLANK  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - COLS);

  state_t            state_r, state_nxt;
  tcw_in_t           in_r, in_nxt;
  logic [6:0]        col_r, col_nxt;
  logic [4:0]        row_r, row_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_r, out_nxt;

  logic [7:0]        pc_col;
  logic [5:0]        pc_row;
  logic              printable;
  logic              need_scroll;
  logic [6:0]        sat_col;
  logic [4:0]        sat_row;
  logic [AW-1:0]     put_addr;
  logic [AW-1:0]     rd_addr;
  logic [IDXC_W-1:0] cur_idx;
  logic [CELL_W-1:0] blank;

  assign blank = {color, CH_SPACE};

  // cursor update for a put
  always_comb begin
    pc_col    = {1'b0, col_r};
    pc_row    = {1'b0, row_r};
    printable = (in_r.char_code[7] == 1'b0) && (in_r.char_code >= CH_SPACE);
    case (in_r.char_code)
      CH_BS: begin
        if (pc_col != 8'd0) begin
          pc_col = pc_col - 8'd1;
        end
      end
      CH_TAB: begin
        pc_col = (pc_col + TAB_STEP) & ~(TAB_STEP - 8'd1);
      end
      CH_CR: begin
        pc_col = 8'd0;
      end
      CH_LF: begin
        pc_col = 8'd0;
        pc_row = pc_row + 6'd1;
      end
      default: begin
      end
    endcase
    if (printable) begin
      pc_col = pc_col + 8'd1;
    end
    if (pc_col >= 8'(COLS)) begin
      pc_col = 8'd0;
      pc_row = pc_row + 6'd1;
    end
    need_scroll = pc_row >= 6'(ROWS);
  end

  always_comb begin
    sat_col  = (in_r.col > 7'(COLS - 1)) ? 7'(COLS - 1) : in_r.col;
    sat_row  = (in_r.row > 5'(ROWS - 1)) ? 5'(ROWS - 1) : in_r.row;
    put_addr = AW'(row_r) * AW'(COLS) + AW'(col_r);
    rd_addr  = AW'(sat_row) * AW'(COLS) + AW'(sat_col);
    cur_idx  = IDXC_W'(row_r) * IDXC_W'(COLS) + IDXC_W'(col_r);
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cell_nxt      = cell_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    // scroll copy: write back the row-below cell read last cycle
    if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = mem_rdata;
    end

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = RESET_CELL;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_nxt = '0;
        case (in_r.cmd)
          CMD_PUT: begin
            if (printable) begin
              mem_we    = 1'b1;
              mem_waddr = put_addr;
              mem_wdata = {color, in_r.char_code};
            end
            col_nxt = pc_col[6:0];
            if (need_scroll) begin
              row_nxt   = 5'(ROWS - 1);
              cnt_nxt   = '0;
              state_nxt = S_SCROLL;
            end else begin
              row_nxt   = pc_row[4:0];
              state_nxt = S_DONE;
            end
          end
          CMD_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          CMD_SET: begin
            col_nxt   = sat_col;
            row_nxt   = sat_row;
            state_nxt = S_DONE;
          end
          default: begin
            mem_re    = 1'b1;
            mem_raddr = rd_addr;
            state_nxt = S_RDWAIT;
          end
        endcase
      end
      S_RDWAIT: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = blank;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_SCROLL: begin
        mem_re        = 1'b1;
        mem_raddr     = cnt_r + AW'(COLS);
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        if (cnt_r == LAST_COPY) begin
          cnt_nxt   = LAST_ROW0;
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_BLANK: begin
        // the write port goes to the last copy first
        if (!pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = blank;
          if (cnt_r == LAST_CELL) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      S_DONE: begin
        out_valid_nxt        = 1'b1;
        out_nxt.cursor_col   = col_r;
        out_nxt.cursor_row   = row_r;
        out_nxt.cursor_index = cur_idx[IDX_W-1:0];
        out_nxt.cell_data    = cell_r;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    pend_addr_r <= pend_addr_nxt;
    cell_r      <= cell_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Put, set cursor: the block steps through EXEC and DONE, and the result strobe is registered; read adds RDWAIT.
// Clear and a put that scrolls walk over the text memory through its one write port.
// busy drops in the strobe cycle, so a new item can be taken there.
// The receiver cannot stall. After reset the text memory is filled with blanks 0x0720,
// one cell a cycle, with busy high; cfg writes are taken meanwhile.
`timescale 1ns / 1ps

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tcw_in_t            in_data,
  output logic               busy,
  output logic               out_valid,
  output tcw_out_t           out_data,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [COLOR_W-1:0] color_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      color_r <= cfg_wdata;
    end
  end

  tcw_seq #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .color     (color_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  tcw_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.cursor_col} < 8'(COLS)) &&
                  ({1'b0, out_data.cursor_row} < 6'(ROWS)))
    else $error("cursor outside the screen");

endmodule
